// File: design/rpn_stack_calculator_core_defines.svh
// Assertion macros shared by the RPN stack calculator RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define RSC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rsc: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define RSC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rsc: next-cycle check failed");

`endif

// File: design/rsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RPN stack calculator.
// Used by rsc_cell, rsc_alu and rpn_stack_calculator_core; depends on nothing.
package rsc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 4'd0,
        KIND_PTOP    = 4'd1,
        KIND_PALL    = 4'd2,
        KIND_ADD     = 4'd3,
        KIND_SUB     = 4'd4,
        KIND_MUL     = 4'd5,
        KIND_DIV     = 4'd6,
        KIND_CLEAR   = 4'd7,
        KIND_UNKNOWN = 4'd8
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_VALUE   = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_UNKNOWN = 3'd2,
        STAT_DIVZERO = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    // Cell moves: hold, shift toward the bottom (push), shift toward the top
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_DOWN = 2'd1,
        CELL_UP   = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     bottom;   // this cell is the lowest live entry during a rotate
    } cell_ctrl_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

// File: design/rpn_stack_calculator_core.sv
// Push and clear act in the idle state; add, sub, mul and div pop once the ALU is done,
// div after the one-bit-per-cycle divider; print-top and errors go through the emit state.
// Print-all gives one word per cycle while the output is free, one step of the cell rotate.
// Throughput: one token at a time; the next token is taken once the current one is done.
// Reset (aresetn low, synchronous): stack empty, output idle; cell contents are not cleared.
`timescale 1ns / 1ps
// Top level: token decoder, control sequencer, row of stack cells and output register.
// Depends on rsc_pkg, rsc_cell, rsc_alu and rpn_stack_calculator_core_defines.svh.
`include "rpn_stack_calculator_core_defines.svh"
module rpn_stack_calculator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] number
    input  logic [3:0]  s_tuser,    // [3:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] value
    output logic [2:0]  m_tuser,    // [2:0] status
    output logic        m_tlast
);

    localparam int N  = rsc_pkg::STACK_DEPTH;
    localparam int DW = rsc_pkg::DEPTH_W;
    localparam int W  = rsc_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ARITH = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_WALK  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [DW-1:0]     remain_reg, remain_next;
    rsc_pkg::status_t  pend_reg, pend_next;

    logic              out_valid_reg;
    logic [W-1:0]      out_data_reg;
    rsc_pkg::status_t  out_status_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              out_load;
    logic [W-1:0]      load_data;
    rsc_pkg::status_t  load_status;
    logic              load_last;

    rsc_pkg::cell_op_t   cell_op;
    rsc_pkg::cell_ctrl_t cell_ctrl [N];
    logic [W-1:0]        cell_q [N];
    logic [W-1:0]        top_below;

    rsc_pkg::alu_req_t alu_req;
    rsc_pkg::alu_op_t  alu_op;
    logic              alu_done;
    logic [W-1:0]      alu_result;
    rsc_pkg::kind_t    kind;

    assign kind     = rsc_pkg::kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Map the token kind to the ALU operation
    always_comb begin
        case (kind)
            rsc_pkg::KIND_ADD: alu_op = rsc_pkg::ALU_ADD;
            rsc_pkg::KIND_SUB: alu_op = rsc_pkg::ALU_SUB;
            rsc_pkg::KIND_MUL: alu_op = rsc_pkg::ALU_MUL;
            default:           alu_op = rsc_pkg::ALU_DIV;
        endcase
    end

    // Sequencer: decode a token, then run its arithmetic, result or print walk
    always_comb begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        remain_next = remain_reg;
        pend_next   = pend_reg;
        cell_op     = rsc_pkg::CELL_HOLD;
        alu_req     = '{start: 1'b0, op: alu_op};
        out_load    = 1'b0;
        load_data   = '0;
        load_status = rsc_pkg::STAT_VALUE;
        load_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (kind)
                        rsc_pkg::KIND_PUSH: begin
                            if (depth_reg == DW'(N)) begin
                                pend_next  = rsc_pkg::STAT_FULL;
                                state_next = ST_EMIT;
                            end else begin
                                cell_op    = rsc_pkg::CELL_DOWN;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        rsc_pkg::KIND_PTOP: begin
                            pend_next  = (depth_reg == '0) ? rsc_pkg::STAT_EMPTY
                                                           : rsc_pkg::STAT_VALUE;
                            state_next = ST_EMIT;
                        end
                        rsc_pkg::KIND_PALL: begin
                            if (depth_reg == '0) begin
                                pend_next  = rsc_pkg::STAT_EMPTY;
                                state_next = ST_EMIT;
                            end else begin
                                remain_next = depth_reg;
                                state_next  = ST_WALK;
                            end
                        end
                        rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB,
                        rsc_pkg::KIND_MUL, rsc_pkg::KIND_DIV: begin
                            if (depth_reg < DW'(2)) begin
                                pend_next  = rsc_pkg::STAT_EMPTY;
                                state_next = ST_EMIT;
                            end else if ((kind == rsc_pkg::KIND_DIV) && (cell_q[0] == '0)) begin
                                pend_next  = rsc_pkg::STAT_DIVZERO;
                                state_next = ST_EMIT;
                            end else begin
                                alu_req.start = 1'b1;
                                state_next    = ST_ARITH;
                            end
                        end
                        rsc_pkg::KIND_CLEAR: begin
                            depth_next = '0;
                        end
                        default: begin
                            pend_next  = rsc_pkg::STAT_UNKNOWN;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_ARITH: begin
                // Pop both operands and push the result in one shift
                if (alu_done) begin
                    cell_op    = rsc_pkg::CELL_UP;
                    depth_next = depth_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    load_status = pend_reg;
                    load_data   = (pend_reg == rsc_pkg::STAT_VALUE) ? cell_q[0] : '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_WALK: begin
                // Send the top word and rotate the live entries by one
                if (out_free) begin
                    out_load    = 1'b1;
                    load_data   = cell_q[0];
                    load_last   = (remain_reg == DW'(1));
                    cell_op     = rsc_pkg::CELL_UP;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == DW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            depth_reg <= '0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        remain_reg <= remain_next;
        pend_reg   <= pend_next;
    end

    // Output register: load a word when free, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg   <= load_data;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // The top cell takes the ALU result when arithmetic pops
    assign top_below = (state_reg == ST_ARITH) ? alu_result : cell_q[1];

    // Row of stack cells, top entry in cell 0
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        assign cell_ctrl[gi] = '{
            op:     cell_op,
            bottom: (state_reg == ST_WALK) && (DW'(gi + 1) == depth_reg)
        };
        if (gi == 0) begin : g_top
            rsc_cell u_cell (
                .aclk   (aclk),
                .ctrl   (cell_ctrl[gi]),
                .above  (s_tdata),
                .below  (top_below),
                .wrap   (cell_q[0]),
                .data_q (cell_q[gi])
            );
        end else if (gi == N - 1) begin : g_last
            rsc_cell u_cell (
                .aclk   (aclk),
                .ctrl   (cell_ctrl[gi]),
                .above  (cell_q[gi-1]),
                .below  (cell_q[0]),
                .wrap   (cell_q[0]),
                .data_q (cell_q[gi])
            );
        end else begin : g_mid
            rsc_cell u_cell (
                .aclk   (aclk),
                .ctrl   (cell_ctrl[gi]),
                .above  (cell_q[gi-1]),
                .below  (cell_q[gi+1]),
                .wrap   (cell_q[0]),
                .data_q (cell_q[gi])
            );
        end
    end

    rsc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (cell_q[1]),
        .opb     (cell_q[0]),
        .done    (alu_done),
        .result  (alu_result)
    );

    `RSC_ASSERT_NOW(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= DW'(N))
    `RSC_ASSERT_NOW(a_done_in_arith, aclk, aresetn, alu_done, state_reg == ST_ARITH)
    `RSC_ASSERT_NEXT(a_walk_ends, aclk, aresetn, out_load && load_last, state_reg == ST_IDLE)
    `RSC_ASSERT_NEXT(a_push_grows, aclk, aresetn, s_tvalid && s_tready && (kind == rsc_pkg::KIND_PUSH) && (depth_reg != DW'(N)), depth_reg == $past(depth_reg) + 1'b1)

endmodule

// File: design/rsc_cell.sv
`timescale 1ns / 1ps
// One stack cell: holds a single 32-bit entry and trades it with its neighbors.
// Depends on rsc_pkg.
module rsc_cell (
    input  logic                       aclk,
    input  rsc_pkg::cell_ctrl_t        ctrl,
    input  logic [rsc_pkg::DATA_W-1:0] above,   // neighbor nearer the top
    input  logic [rsc_pkg::DATA_W-1:0] below,   // neighbor nearer the bottom
    input  logic [rsc_pkg::DATA_W-1:0] wrap,    // top entry, taken by the bottom on rotate
    output logic [rsc_pkg::DATA_W-1:0] data_q
);

    logic [rsc_pkg::DATA_W-1:0] data_reg;
    logic [rsc_pkg::DATA_W-1:0] data_next;

    // Select the next entry from the requested move
    always_comb begin
        case (ctrl.op)
            rsc_pkg::CELL_HOLD: data_next = data_reg;
            rsc_pkg::CELL_DOWN: data_next = above;
            rsc_pkg::CELL_UP:   data_next = ctrl.bottom ? wrap : below;
            default:            data_next = data_reg;
        endcase
    end

    // Hold the entry; contents are undefined until written
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// File: design/rsc_alu.sv
`timescale 1ns / 1ps
// Arithmetic unit: registered add, sub and mul, and a bit-serial restoring signed divide.
// Depends on rsc_pkg and rpn_stack_calculator_core_defines.svh.
`include "rpn_stack_calculator_core_defines.svh"
module rsc_alu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsc_pkg::alu_req_t          req,
    input  logic [rsc_pkg::DATA_W-1:0] opa,     // second entry (s)
    input  logic [rsc_pkg::DATA_W-1:0] opb,     // top entry (t)
    output logic                       done,
    output logic [rsc_pkg::DATA_W-1:0] result
);

    localparam int W         = rsc_pkg::DATA_W;
    localparam int DIV_CNT_W = rsc_pkg::DIV_CNT_W;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [W-1:0]         quo_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         dvs_reg;
    logic                 neg_reg;
    logic [W-1:0]         result_reg;

    logic [W-1:0]   opa_mag;
    logic [W-1:0]   opb_mag;
    logic [2*W-1:0] product;
    logic [W-1:0]   rem_shift;
    logic [W:0]     diff;

    assign opa_mag   = opa[W-1] ? (~opa + 1'b1) : opa;
    assign opb_mag   = opb[W-1] ? (~opb + 1'b1) : opb;
    assign product   = opa * opb;
    assign rem_shift = {rem_reg[W-2:0], quo_reg[W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, dvs_reg};

    // Control: busy across the divide, done pulses once per request
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            if (req.op == rsc_pkg::ALU_DIV) begin
                busy_next = 1'b1;
            end else begin
                done_next = 1'b1;
            end
        end else if (busy_reg && (cnt_reg == '0)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath: add, sub and mul registered directly, or one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            case (req.op)
                rsc_pkg::ALU_ADD: result_reg <= opa + opb;
                rsc_pkg::ALU_SUB: result_reg <= opa - opb;
                rsc_pkg::ALU_MUL: result_reg <= product[W-1:0];
                rsc_pkg::ALU_DIV: begin
                    quo_reg <= opa_mag;
                    rem_reg <= '0;
                    dvs_reg <= opb_mag;
                    neg_reg <= opa[W-1] ^ opb[W-1];
                    cnt_reg <= DIV_CNT_W'(W);
                end
                default: result_reg <= result_reg;
            endcase
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                if (!diff[W]) begin
                    rem_reg <= diff[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                // Apply the sign; most negative / -1 wraps by itself
                result_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RSC_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg)
    `RSC_ASSERT_NEXT(a_div_busy, aclk, aresetn, req.start && (req.op == rsc_pkg::ALU_DIV), busy_reg)
    `RSC_ASSERT_NOW(a_no_start_busy, aclk, aresetn, busy_reg, !req.start)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator_core: streams classified tokens,
// predicts every result word from its own stack model and checks the output stream.
// Depends on rsc_pkg and the rpn_stack_calculator_core RTL.
module tb;
    import rsc_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [31:0]       number;
    } token_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [STACK_DEPTH-1:0][31:0] mem;
        logic [DEPTH_W-1:0]           depth;
    } calc_state_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_t      token_q[$];
    result_t     expected_q[$];
    result_t     scratch_q[$];
    calc_state_t gen_state  = '0;
    calc_state_t pred_state = '0;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_req    = 0;
    int  hold_ack    = 0;
    int  hold_left   = 0;
    logic in_fire    = 1'b0;

    int errors       = 0;
    int n_tokens     = 0;
    int n_words      = 0;
    int n_status     = 0;
    int max_depth    = 0;
    int stall_cycles = 0;

    rpn_stack_calculator_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic result_t status_word(status_t st);
        result_t r;
        r.status = st;
        r.value  = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    // Apply one token to a calculator state and append the result words it causes
    function automatic void calc_token(inout calc_state_t st, input logic [3:0] kind,
                                       input logic [31:0] num, ref result_t out_q[$]);
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] r;
        longint      q;
        result_t     w;
        case (kind)
            KIND_PUSH: begin
                if (st.depth >= STACK_DEPTH) begin
                    out_q.push_back(status_word(STAT_FULL));
                end else begin
                    st.mem[st.depth] = num;
                    st.depth = st.depth + 1'b1;
                end
            end
            KIND_PTOP, KIND_PALL: begin
                if (st.depth == 0) begin
                    out_q.push_back(status_word(STAT_EMPTY));
                end else begin
                    // walk from the top down; only print-all goes past the top word
                    for (int i = st.depth; i > 0; i--) begin
                        w.status = STAT_VALUE;
                        w.value  = st.mem[i-1];
                        w.last   = (i == 1) || (kind == KIND_PTOP);
                        out_q.push_back(w);
                        if (kind == KIND_PTOP) break;
                    end
                end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (st.depth < 2) begin
                    out_q.push_back(status_word(STAT_EMPTY));
                end else begin
                    t = st.mem[st.depth-1];
                    s = st.mem[st.depth-2];
                    if (kind == KIND_DIV && t == 0) begin
                        out_q.push_back(status_word(STAT_DIVZERO));
                        return;
                    end
                    case (kind)
                        KIND_ADD: r = s + t;
                        KIND_SUB: r = s - t;
                        KIND_MUL: r = s * t;
                        default: begin
                            // 64-bit quotient truncates toward zero and wraps min/-1
                            q = longint'($signed(s)) / longint'($signed(t));
                            r = q[31:0];
                        end
                    endcase
                    st.depth = st.depth - 1'b1;
                    st.mem[st.depth-1] = r;
                end
            end
            KIND_CLEAR: st.depth = '0;
            default: out_q.push_back(status_word(STAT_UNKNOWN));
        endcase
    endfunction

    // Queue a token and track the stack it leaves so random picks can follow it
    task automatic add_token(logic [3:0] kind, logic [31:0] num);
        token_t tok;
        tok.kind   = kind;
        tok.number = num;
        scratch_q.delete();
        calc_token(gen_state, kind, num, scratch_q);
        token_q.push_back(tok);
    endtask

    function automatic logic [31:0] rand_number();
        case ($urandom_range(5))
            0: return 32'($signed($urandom_range(19)) - 10);
            1: return 32'h0;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_token();
        int pick;
        int push_pct;
        logic [3:0] kind;
        pick = $urandom_range(99);
        push_pct = (gen_state.depth < 2) ? 70 : 40;
        if (pick < push_pct)    kind = KIND_PUSH;
        else if (pick < 74)     kind = KIND_ADD;
        else if (pick < 78)     kind = KIND_SUB;
        else if (pick < 83)     kind = KIND_MUL;
        else if (pick < 89)     kind = KIND_DIV;
        else if (pick < 93)     kind = KIND_PTOP;
        else if (pick < 95)     kind = KIND_PALL;
        else if (pick < 96)     kind = KIND_CLEAR;
        else                    kind = 4'($urandom_range(KIND_UNKNOWN, 15));
        add_token(kind, (kind == KIND_PUSH) ? rand_number() : $urandom);
    endtask

    task automatic wait_drained();
        while (token_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_random(int count);
        @(posedge aclk);
        repeat (count) add_random_token();
        wait_drained();
    endtask

    // Token driver: offer the next pending word at the falling edge once the slot is free
    always @(negedge aclk) begin
        token_t tok;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (token_q.size() != 0 && !coin(tx_idle_pct)) begin
                tok = token_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tok.number;
                s_tuser  <= tok.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold when one is requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_tready  <= 1'b0;
            hold_left <= 400;
            hold_ack  <= hold_req;
        end else begin
            m_tready <= !coin(rx_idle_pct);
        end
    end

    // Monitor: check each result word, then predict from each accepted token
    always @(posedge aclk) begin
        result_t want;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            n_words++;
            if (m_tuser != STAT_VALUE) n_status++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word status=%0d value=%h last=%b",
                         $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = expected_q.pop_front();
                if (m_tuser != want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                end
                if (m_tdata != want.value) begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
                end
                if (m_tlast != want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            calc_token(pred_state, s_tuser, s_tdata, expected_q);
            n_tokens++;
            if (pred_state.depth > max_depth) max_depth = pred_state.depth;
        end
        if (hold_left != 0 && s_tvalid && !s_tready) stall_cycles++;
    end

    // Stimulus sequence
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 22;
        rx_idle_pct = 86;
        @(posedge aclk);

        // errors on an empty stack, then wrap, divide and print corners
        add_token(KIND_PTOP, 32'h0);
        add_token(KIND_PALL, 32'hFFFF_FFFF);
        add_token(KIND_ADD, 32'h0);
        add_token(KIND_CLEAR, 32'h0);
        add_token(KIND_PUSH, 32'h7FFF_FFFF);
        add_token(KIND_SUB, 32'h0);
        add_token(KIND_PUSH, 32'h8000_0000);
        add_token(KIND_PALL, 32'h0);
        add_token(KIND_ADD, 32'h0);
        add_token(KIND_PUSH, 32'h0);
        add_token(KIND_DIV, 32'h0);
        add_token(KIND_MUL, 32'h0);
        add_token(KIND_UNKNOWN, 32'h0);
        add_token(4'hF, 32'hFFFF_FFFF);
        add_token(KIND_CLEAR, 32'h0);
        add_token(KIND_PUSH, 32'h8000_0000);
        add_token(KIND_PUSH, 32'hFFFF_FFFF);
        add_token(KIND_DIV, 32'h0);
        add_token(KIND_PTOP, 32'h0);
        add_token(KIND_PUSH, 32'hFFFF_FFF9);
        add_token(KIND_PUSH, 32'h2);
        add_token(KIND_DIV, 32'h0);
        add_token(KIND_SUB, 32'h0);
        add_token(KIND_PALL, 32'h0);
        wait_drained();

        // hold the receiver while the stack fills and overflows, then print it all
        hold_req++;
        add_token(KIND_CLEAR, 32'h0);
        repeat (STACK_DEPTH + 1) add_token(KIND_PUSH, rand_number());
        add_token(KIND_PALL, 32'h0);
        add_token(KIND_PTOP, 32'h0);
        add_token(KIND_PALL, 32'h0);
        wait_drained();

        run_random(103);
        tx_idle_pct = 86;
        rx_idle_pct = 22;
        run_random(103);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(103);

        // let a long divide or stray word surface before closing
        repeat (40) @(posedge aclk);
        if (expected_q.size() != 0) begin
            errors++;
            $display("%0t: %0d result words never arrived", $time, expected_q.size());
        end
        $display("tb: %0d tokens, %0d result words (%0d error statuses), stack depth up to %0d",
                 n_tokens, n_words, n_status, max_depth);
        $display("tb: input held back %0d cycles under output hold, %0d mismatches",
                 stall_cycles, errors);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: timeout at %0t", $time);
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/rsc_pkg.sv
design/rsc_cell.sv
design/rsc_alu.sv
design/rpn_stack_calculator_core.sv
test/tb.sv
